// ----- rtl/srfu_pkg.sv -----
// ----------------------------------------------------------------------------
// srfu_pkg
// Shared types, codes and size helpers for the shift/rotate flags unit.
// ----------------------------------------------------------------------------
package srfu_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned CNT_W    = 6;
   localparam int unsigned FUNNEL_W = 96;  // covers a 63-bit shift with a 33-bit tap
   localparam int unsigned WIN_W    = 40;  // left after the coarse byte shift
   localparam int unsigned TAP_W    = 33;

   localparam logic [1:0] KIND_ASH  = 2'd0;  // arithmetic shift
   localparam logic [1:0] KIND_LSH  = 2'd1;  // logical shift
   localparam logic [1:0] KIND_ROXR = 2'd2;  // rotate through extend
   localparam logic [1:0] KIND_ROT  = 2'd3;  // rotate

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_WORD = 2'd1;
   localparam logic [1:0] SIZE_LONG = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0] operand;
      logic [1:0]        shift_kind;
      logic              to_left;
      logic [1:0]        operand_size;
      logic [CNT_W-1:0]  shift_count;
      logic              extend_in;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] shifted;
      logic              extend_out;
      logic              negative;
      logic              zero;
      logic              overflow;
      logic              carry_out;
   } rsp_type;

   // sideband that rides along with each item through the pipe
   typedef struct packed {
      logic [1:0] kind;
      logic       to_left;
      logic [1:0] size;
      logic       count_nz;
      logic       asr_big;    // arithmetic right with count above width
      logic       cnt_ge_w;
      logic [4:0] cnt_lo;
      logic       ext_in;
   } ctl_type;

   function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] size);
      logic [DATA_W-1:0] m;
      case (size)
         SIZE_BYTE: m = 32'h0000_00FF;
         SIZE_WORD: m = 32'h0000_FFFF;
         default:   m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

   function automatic logic [CNT_W-1:0] size_width(input logic [1:0] size);
      logic [CNT_W-1:0] w;
      case (size)
         SIZE_BYTE: w = 6'd8;
         SIZE_WORD: w = 6'd16;
         default:   w = 6'd32;
      endcase
      return w;
   endfunction

   function automatic logic size_msb(input logic [DATA_W-1:0] d, input logic [1:0] size);
      logic b;
      case (size)
         SIZE_BYTE: b = d[7];
         SIZE_WORD: b = d[15];
         default:   b = d[31];
      endcase
      return b;
   endfunction

   // bit reverse within the operand size, upper bits cleared
   function automatic logic [DATA_W-1:0] rev_size(input logic [DATA_W-1:0] d,
                                                 input logic [1:0] size);
      logic [DATA_W-1:0] r;
      r = '0;
      case (size)
         SIZE_BYTE: for (int i = 0; i < 8; i++)  r[i] = d[7-i];
         SIZE_WORD: for (int i = 0; i < 16; i++) r[i] = d[15-i];
         default:   for (int i = 0; i < 32; i++) r[i] = d[31-i];
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/shift_rotate_flags_unit_top.sv -----
// ----------------------------------------------------------------------------
// shift_rotate_flags_unit_top
// Shift/rotate unit with condition flags: prep, coarse shift, fine shift and
// flag stages; one item may start in every cycle.
// ----------------------------------------------------------------------------
// rsp_valid strobes once an accepted item has passed the prep, coarse, fine and flag registers.
// Throughput: one item per cycle for any count, set by the four-stage pipe.
// busy is high only while reset is asserted; the receiver never stalls.
// Reset clears the stage valid bits; items in flight are dropped.
module shift_rotate_flags_unit_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  srfu_pkg::req_type   req_data,
   output logic                rsp_valid,
   output srfu_pkg::rsp_type   rsp_data
);
   import srfu_pkg::*;

   logic                s1_valid;
   logic [FUNNEL_W-1:0] s1_funnel;
   logic [CNT_W-1:0]    s1_amount;
   ctl_type             s1_ctl;
   logic                s3_valid;
   logic [TAP_W-1:0]    s3_tap;
   logic                s3_ovf;
   ctl_type             s3_ctl;

   logic [DATA_W-1:0]   raw;
   logic [DATA_W-1:0]   res;
   logic                neg;
   logic                shift_c;
   rsp_type             rsp_in;

   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   assign busy = reset;

   srfu_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .req       (req_data),
      .s1_valid  (s1_valid),
      .s1_funnel (s1_funnel),
      .s1_amount (s1_amount),
      .s1_ctl    (s1_ctl)
   );

   srfu_shifter u_shifter (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid),
      .s1_funnel (s1_funnel),
      .s1_amount (s1_amount),
      .s1_ctl    (s1_ctl),
      .s3_valid  (s3_valid),
      .s3_tap    (s3_tap),
      .s3_ovf    (s3_ovf),
      .s3_ctl    (s3_ctl)
   );

   always_comb begin
      // rotates tap from bit 0, shifts sit above the guard bit
      if ((s3_ctl.kind == KIND_ROT) || (s3_ctl.kind == KIND_ROXR)) begin
         raw = s3_tap[DATA_W-1:0];
      end else begin
         raw = s3_tap[DATA_W:1];
      end
      if (((s3_ctl.kind == KIND_ASH) || (s3_ctl.kind == KIND_LSH)) && s3_ctl.to_left) begin
         res = rev_size(raw, s3_ctl.size) & size_mask(s3_ctl.size);
      end else begin
         res = raw & size_mask(s3_ctl.size);
      end
      neg     = size_msb(res, s3_ctl.size);
      shift_c = s3_tap[0] && !s3_ctl.asr_big;

      rsp_in.shifted  = res;
      rsp_in.negative = neg;
      rsp_in.zero     = (res == '0);
      rsp_in.overflow = (s3_ctl.kind == KIND_ASH) && s3_ctl.to_left && s3_ovf;

      case (s3_ctl.kind)
         KIND_ROXR: begin
            // extend lands just above the operand
            case (s3_ctl.size)
               SIZE_BYTE: rsp_in.extend_out = s3_tap[8];
               SIZE_WORD: rsp_in.extend_out = s3_tap[16];
               default:   rsp_in.extend_out = s3_tap[32];
            endcase
            rsp_in.carry_out = rsp_in.extend_out;
         end
         KIND_ROT: begin
            rsp_in.extend_out = s3_ctl.ext_in;
            rsp_in.carry_out  = s3_ctl.count_nz && (s3_ctl.to_left ? res[0] : neg);
         end
         default: begin
            rsp_in.extend_out = s3_ctl.count_nz ? shift_c : s3_ctl.ext_in;
            rsp_in.carry_out  = s3_ctl.count_nz && shift_c;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s3_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // every strobe traces back to exactly one accepted item
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("result strobe without a matching accepted item");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      ($past(start && !busy, 4) && !$past(reset, 1) && !$past(reset, 2)
       && !$past(reset, 3)) |-> rsp_valid)
      else $error("accepted item produced no result");

   a_ovf_only_asl: assert property (@(posedge clock) disable iff (reset)
      (s3_valid && !((s3_ctl.kind == KIND_ASH) && s3_ctl.to_left)) |=> !rsp_data.overflow)
      else $error("overflow set outside arithmetic left shift");

   a_rot_keeps_x: assert property (@(posedge clock) disable iff (reset)
      (s3_valid && (s3_ctl.kind == KIND_ROT)) |=> (rsp_data.extend_out == $past(s3_ctl.ext_in)))
      else $error("plain rotate changed the extend flag");

   a_zero_not_neg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.zero && rsp_data.negative))
      else $error("result flagged both zero and negative");

endmodule

// ----- rtl/srfu_prep.sv -----
// ----------------------------------------------------------------------------
// srfu_prep
// First stage: masks the operand and builds the funnel word and the right
// shift amount that turn every shift kind into one right-shift window.
// ----------------------------------------------------------------------------
module srfu_prep (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  srfu_pkg::req_type                     req,
   output logic                                  s1_valid,
   output logic [srfu_pkg::FUNNEL_W-1:0]         s1_funnel,
   output logic [srfu_pkg::CNT_W-1:0]            s1_amount,
   output srfu_pkg::ctl_type                     s1_ctl
);
   import srfu_pkg::*;

   logic [DATA_W-1:0]   mask;
   logic [DATA_W-1:0]   r;
   logic [DATA_W-1:0]   src;
   logic [DATA_W-1:0]   fill;
   logic [CNT_W-1:0]    width;
   logic [CNT_W-1:0]    count;
   logic [CNT_W-1:0]    rot_k;
   logic [CNT_W-1:0]    rox_k;
   logic                neg;
   logic                asr;
   logic                x;
   logic [FUNNEL_W-1:0] funnel_in;
   logic [CNT_W-1:0]    amount_in;
   ctl_type             ctl_in;

   logic                valid_ff;
   logic [FUNNEL_W-1:0] funnel_ff;
   logic [CNT_W-1:0]    amount_ff;
   ctl_type             ctl_ff;

   always_comb begin
      mask  = size_mask(req.operand_size);
      width = size_width(req.operand_size);
      r     = req.operand & mask;
      neg   = size_msb(r, req.operand_size);
      count = req.shift_count;
      x     = req.extend_in;
      asr   = (req.shift_kind == KIND_ASH) && !req.to_left;
      rot_k = count & (width - 6'd1);

      // count mod (width + 1) by conditional subtraction
      rox_k = count;
      case (req.operand_size)
         SIZE_BYTE: begin
            if (rox_k >= 6'd36) rox_k = rox_k - 6'd36;
            if (rox_k >= 6'd18) rox_k = rox_k - 6'd18;
            if (rox_k >= 6'd9)  rox_k = rox_k - 6'd9;
         end
         SIZE_WORD: begin
            if (rox_k >= 6'd34) rox_k = rox_k - 6'd34;
            if (rox_k >= 6'd17) rox_k = rox_k - 6'd17;
         end
         default: begin
            if (rox_k >= 6'd33) rox_k = rox_k - 6'd33;
         end
      endcase

      // left shifts run as right shifts of the reversed operand
      src  = req.to_left ? rev_size(r, req.operand_size) : r;
      fill = (asr && neg) ? ~mask : '0;

      case (req.shift_kind)
         KIND_ROT: begin
            case (req.operand_size)
               SIZE_BYTE: funnel_in = {80'b0, r[7:0], r[7:0]};
               SIZE_WORD: funnel_in = {64'b0, r[15:0], r[15:0]};
               default:   funnel_in = {32'b0, r, r};
            endcase
            amount_in = req.to_left ? ((width - rot_k) & (width - 6'd1)) : rot_k;
         end
         KIND_ROXR: begin
            case (req.operand_size)
               SIZE_BYTE: funnel_in = {78'b0, x, r[7:0], x, r[7:0]};
               SIZE_WORD: funnel_in = {62'b0, x, r[15:0], x, r[15:0]};
               default:   funnel_in = {30'b0, x, r, x, r};
            endcase
            if (req.to_left && (rox_k != '0)) begin
               amount_in = width + 6'd1 - rox_k;
            end else begin
               amount_in = req.to_left ? '0 : rox_k;
            end
         end
         default: begin
            // guard bit at the bottom catches the last bit shifted out
            funnel_in = {{63{asr && neg}}, src | fill, 1'b0};
            amount_in = count;
         end
      endcase

      ctl_in.kind     = req.shift_kind;
      ctl_in.to_left  = req.to_left;
      ctl_in.size     = req.operand_size;
      ctl_in.count_nz = (count != '0);
      ctl_in.asr_big  = asr && (count > width);
      ctl_in.cnt_ge_w = (count >= width);
      ctl_in.cnt_lo   = count[4:0];
      ctl_in.ext_in   = x;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      funnel_ff <= funnel_in;
      amount_ff <= amount_in;
      ctl_ff    <= ctl_in;
   end

   assign s1_valid  = valid_ff;
   assign s1_funnel = funnel_ff;
   assign s1_amount = amount_ff;
   assign s1_ctl    = ctl_ff;

endmodule

// ----- rtl/srfu_shifter.sv -----
// ----------------------------------------------------------------------------
// srfu_shifter
// Two-stage right funnel shifter (coarse by bytes, then fine by bits), with
// the arithmetic-left overflow check alongside the coarse stage.
// ----------------------------------------------------------------------------
module srfu_shifter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  s1_valid,
   input  logic [srfu_pkg::FUNNEL_W-1:0]         s1_funnel,
   input  logic [srfu_pkg::CNT_W-1:0]            s1_amount,
   input  srfu_pkg::ctl_type                     s1_ctl,
   output logic                                  s3_valid,
   output logic [srfu_pkg::TAP_W-1:0]            s3_tap,
   output logic                                  s3_ovf,
   output srfu_pkg::ctl_type                     s3_ctl
);
   import srfu_pkg::*;

   logic [WIN_W-1:0]  win_in;
   logic [DATA_W-1:0] rv;
   logic [DATA_W-1:0] top_mask;
   logic [DATA_W-1:0] top_bits;
   logic              ovf_in;
   logic [TAP_W-1:0]  tap_in;

   logic              s2_valid_ff;
   logic [WIN_W-1:0]  s2_win_ff;
   logic [2:0]        s2_lo_ff;
   logic              s2_ovf_ff;
   ctl_type           s2_ctl_ff;

   logic              s3_valid_ff;
   logic [TAP_W-1:0]  s3_tap_ff;
   logic              s3_ovf_ff;
   ctl_type           s3_ctl_ff;

   always_comb begin
      win_in = s1_funnel[{s1_amount[5:3], 3'b000} +: WIN_W];

      // reversed operand of a left shift: bit 0 holds the sign. Overflow when
      // the bits that pass through the sign position are not all equal.
      rv       = s1_funnel[DATA_W:1];
      top_mask = ~(32'hFFFF_FFFE << s1_ctl.cnt_lo);
      top_bits = rv & top_mask;
      if (s1_ctl.cnt_ge_w) begin
         ovf_in = (rv != '0);
      end else begin
         ovf_in = (top_bits != '0) && (top_bits != top_mask);
      end
   end

   always_comb begin
      tap_in = s2_win_ff[s2_lo_ff +: TAP_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_win_ff <= win_in;
      s2_lo_ff  <= s1_amount[2:0];
      s2_ovf_ff <= ovf_in;
      s2_ctl_ff <= s1_ctl;
      s3_tap_ff <= tap_in;
      s3_ovf_ff <= s2_ovf_ff;
      s3_ctl_ff <= s2_ctl_ff;
   end

   assign s3_valid = s3_valid_ff;
   assign s3_tap   = s3_tap_ff;
   assign s3_ovf   = s3_ovf_ff;
   assign s3_ctl   = s3_ctl_ff;

endmodule

// ----- test/tb_shift_rotate_flags_unit_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shift_rotate_flags_unit_top
// Self-checking bench for the shift/rotate flags unit. A directed burst
// covers the corner cases. Random items follow, with the sender idling at
// several rates. Each accepted item is predicted bit for bit, and each result
// strobe is compared, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_shift_rotate_flags_unit_top;
   import srfu_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;     // pipe is four deep
   localparam int MAX_REPORTS = 10;

   typedef struct {
      req_type item;
      rsp_type want;
   } pending_type;

   class shift_flags_scoreboard;
      pending_type pending_q[$];
      int mismatches;
      int results_seen;
      int items_noted;

      function new();
         mismatches   = 0;
         results_seen = 0;
         items_noted  = 0;
      endfunction

      // bitwise prediction of one item; size code 3 falls back to long
      function rsp_type predict_shift(req_type q);
         rsp_type e;
         int unsigned width, cnt;
         logic [31:0] mask, sgn, r, n;
         logic x, c, v, neg, out_bit;
         case (q.operand_size)
            SIZE_BYTE: begin
               width = 8;  mask = 32'h0000_00FF; sgn = 32'h0000_0080;
            end
            SIZE_WORD: begin
               width = 16; mask = 32'h0000_FFFF; sgn = 32'h0000_8000;
            end
            default: begin
               width = 32; mask = 32'hFFFF_FFFF; sgn = 32'h8000_0000;
            end
         endcase
         cnt = 32'(q.shift_count);
         x   = q.extend_in;
         c   = 1'b0;
         v   = 1'b0;
         r   = q.operand & mask;
         if (q.shift_kind == KIND_ASH && !q.to_left) begin
            neg = (r & sgn) != 0;
            if (cnt == 0) begin
               c = 1'b0;
            end else if (cnt < width) begin
               c = r[cnt-1];
               r = r >> cnt;
               if (neg) r = r | ((mask << (width - cnt)) & mask);
               x = c;
            end else begin
               // carry survives only when exactly the width is shifted out
               c = (cnt == width) && neg;
               r = neg ? mask : 32'h0;
               x = c;
            end
         end else if (cnt == 0) begin
            c = (q.shift_kind == KIND_ROXR) && x;
         end else begin
            for (int i = 0; i < cnt; i++) begin
               if (q.to_left) begin
                  out_bit = (r & sgn) != 0;
                  n = (r << 1) & mask;
                  if (q.shift_kind == KIND_ASH && ((r ^ n) & sgn) != 0) v = 1'b1;
                  else if (q.shift_kind == KIND_ROXR && x) n = n | 32'h1;
                  else if (q.shift_kind == KIND_ROT && out_bit) n = n | 32'h1;
               end else begin
                  out_bit = r[0];
                  n = (r >> 1) & mask;
                  if (q.shift_kind == KIND_ROXR && x) n = n | sgn;
                  else if (q.shift_kind == KIND_ROT && out_bit) n = n | sgn;
               end
               c = out_bit;
               if (q.shift_kind != KIND_ROT) x = out_bit;
               r = n;
            end
         end
         e.shifted    = r & mask;
         e.extend_out = x;
         e.negative   = (r & sgn) != 0;
         e.zero       = (r & mask) == 0;
         e.overflow   = (q.shift_kind == KIND_ASH) && q.to_left && v;
         e.carry_out  = c;
         return e;
      endfunction

      function void note_item(req_type q);
         pending_type p;
         p.item = q;
         p.want = predict_shift(q);
         pending_q.push_back(p);
         items_noted++;
      endfunction

      function void check_result(rsp_type got);
         pending_type p;
         results_seen++;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: result with no item outstanding: %h", got);
            return;
         end
         p = pending_q.pop_front();
         if (got.shifted !== p.want.shifted || got.extend_out !== p.want.extend_out ||
             got.negative !== p.want.negative || got.zero !== p.want.zero ||
             got.overflow !== p.want.overflow || got.carry_out !== p.want.carry_out) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("ERROR: op=%h kind=%0d left=%0b size=%0d cnt=%0d x=%0b",
                        p.item.operand, p.item.shift_kind, p.item.to_left,
                        p.item.operand_size, p.item.shift_count, p.item.extend_in);
               $display("   expected val=%h x=%b n=%b z=%b v=%b c=%b",
                        p.want.shifted, p.want.extend_out, p.want.negative,
                        p.want.zero, p.want.overflow, p.want.carry_out);
               $display("   actual   val=%h x=%b n=%b z=%b v=%b c=%b",
                        got.shifted, got.extend_out, got.negative,
                        got.zero, got.overflow, got.carry_out);
            end
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   shift_flags_scoreboard sb;
   int accept_count;
   int cycle_count;

   shift_rotate_flags_unit_top DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // values read here are the ones that stood before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sb.note_item(req_data);
            accept_count++;
         end
         if (rsp_valid) sb.check_result(rsp_data);
      end
   end

   function automatic req_type make_item(logic [31:0] op, logic [1:0] kind, logic left,
                                         logic [1:0] size, logic [5:0] cnt, logic x);
      req_type q;
      q.operand      = op;
      q.shift_kind   = kind;
      q.to_left      = left;
      q.operand_size = size;
      q.shift_count  = cnt;
      q.extend_in    = x;
      return q;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic drive_item(req_type q, int idle_pct);
      int seen;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      seen = accept_count;
      start    <= 1'b1;
      req_data <= q;
      do @(negedge clock); while (accept_count == seen);
   endtask

   task automatic run_random(int count, int idle_pct);
      req_type q;
      int width;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 5))
            0: q.operand = 32'hFFFF_FFFF;
            1: q.operand = 32'h1 << $urandom_range(0, 31);
            2: q.operand = ~(32'h1 << $urandom_range(0, 31));
            3: q.operand = 32'($urandom_range(0, 255));
            default: q.operand = $urandom;
         endcase
         q.shift_kind   = 2'($urandom_range(0, 3));
         q.to_left      = 1'($urandom_range(0, 1));
         q.operand_size = ($urandom_range(0, 31) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
         q.extend_in    = 1'($urandom_range(0, 1));
         case (q.operand_size)
            SIZE_BYTE: width = 8;
            SIZE_WORD: width = 16;
            default:   width = 32;
         endcase
         // lean on counts around the width
         if ($urandom_range(0, 3) == 0) q.shift_count = 6'(width - 1 + $urandom_range(0, 2));
         else q.shift_count = 6'($urandom_range(0, 63));
         drive_item(q, idle_pct);
      end
   endtask

   initial begin
      sb           = new();
      accept_count = 0;
      cycle_count  = 0;
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // arithmetic left, overflow with and without sign change
      drive_item(make_item(32'h0000_0040, KIND_ASH, 1'b1, SIZE_BYTE, 6'd1, 1'b0), 0);
      drive_item(make_item(32'h0000_0081, KIND_ASH, 1'b1, SIZE_BYTE, 6'd1, 1'b1), 0);
      drive_item(make_item(32'h3FFF_FFFF, KIND_ASH, 1'b1, SIZE_LONG, 6'd63, 1'b0), 0);
      drive_item(make_item(32'hC000_0000, KIND_ASH, 1'b1, SIZE_LONG, 6'd1, 1'b0), 0);
      // arithmetic right below, at and above the width
      drive_item(make_item(32'h0000_0080, KIND_ASH, 1'b0, SIZE_BYTE, 6'd7, 1'b0), 0);
      drive_item(make_item(32'h0000_0080, KIND_ASH, 1'b0, SIZE_BYTE, 6'd8, 1'b0), 0);
      drive_item(make_item(32'h0000_0080, KIND_ASH, 1'b0, SIZE_BYTE, 6'd9, 1'b1), 0);
      drive_item(make_item(32'h0000_8000, KIND_ASH, 1'b0, SIZE_WORD, 6'd16, 1'b0), 0);
      drive_item(make_item(32'h8000_0000, KIND_ASH, 1'b0, SIZE_LONG, 6'd32, 1'b0), 0);
      drive_item(make_item(32'h7FFF_FFFF, KIND_ASH, 1'b0, SIZE_LONG, 6'd32, 1'b1), 0);
      drive_item(make_item(32'hFFFF_FFFF, KIND_ASH, 1'b0, SIZE_LONG, 6'd63, 1'b0), 0);
      // count zero, extend kept; carry follows extend only through extend
      drive_item(make_item(32'h0000_00A5, KIND_ROXR, 1'b1, SIZE_BYTE, 6'd0, 1'b1), 0);
      drive_item(make_item(32'h0000_00A5, KIND_LSH, 1'b1, SIZE_BYTE, 6'd0, 1'b1), 0);
      drive_item(make_item(32'h0000_8001, KIND_ROT, 1'b0, SIZE_WORD, 6'd0, 1'b1), 0);
      drive_item(make_item(32'h8000_0000, KIND_ASH, 1'b0, SIZE_LONG, 6'd0, 1'b1), 0);
      // logical extremes
      drive_item(make_item(32'hFFFF_FFFF, KIND_LSH, 1'b0, SIZE_LONG, 6'd63, 1'b0), 0);
      drive_item(make_item(32'hFFFF_FFFF, KIND_LSH, 1'b1, SIZE_LONG, 6'd32, 1'b0), 0);
      drive_item(make_item(32'hFFFF_FF00, KIND_LSH, 1'b1, SIZE_BYTE, 6'd1, 1'b1), 0);
      // rotates, full turns and past them
      drive_item(make_item(32'h0000_0001, KIND_ROXR, 1'b0, SIZE_BYTE, 6'd9, 1'b1), 0);
      drive_item(make_item(32'h0000_8000, KIND_ROXR, 1'b1, SIZE_WORD, 6'd17, 1'b0), 0);
      drive_item(make_item(32'h0000_0001, KIND_ROT, 1'b0, SIZE_LONG, 6'd33, 1'b0), 0);
      drive_item(make_item(32'h0000_0081, KIND_ROT, 1'b1, SIZE_BYTE, 6'd63, 1'b1), 0);
      // undefined size code behaves as long
      drive_item(make_item(32'h8000_0001, KIND_ROT, 1'b1, 2'd3, 6'd1, 1'b0), 0);
      drive_item(make_item(32'h8000_0000, KIND_ASH, 1'b0, 2'd3, 6'd32, 1'b0), 0);

      run_random(150, 0);
      run_random(150, 48);
      run_random(150, 19);
      run_random(150, 0);
      start <= 1'b0;

      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d items across all shift kinds, directions, size codes and counts 0..63",
               sb.items_noted);
      $display("%0d results checked, %0d mismatches", sb.results_seen, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/srfu_pkg.sv
rtl/srfu_prep.sv
rtl/srfu_shifter.sv
rtl/shift_rotate_flags_unit_top.sv
test/tb_shift_rotate_flags_unit_top.sv
